>>> sv/msspg_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-axis step pulse generator: field widths, operation
// codes, controller states and the command/status structs. No dependencies.
package msspg_pkg;

  // Number of stepper channels held by the block.
  localparam int AXES = 4;

  localparam int OP_W       = 3;
  localparam int AXIS_W     = 3;
  localparam int VAL_W      = 16;
  localparam int LEVEL_W    = 4;
  localparam int POS_W      = 32;
  localparam int NUM_AXES_W = 3;
  localparam int SIGN_W     = 2;

  // Restoring division of 65535 by the speed, one quotient bit per cycle.
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Two-bit direction sign: zero means no counting until a direction is set.
  localparam logic [SIGN_W-1:0] SIGN_FWD = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_REV = 2'b11;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_SET_DELAY = 3'd1,
    OP_SET_SPEED = 3'd2,
    OP_SET_DIR   = 3'd3,
    OP_ENABLE    = 3'd4,
    OP_DISABLE   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic div_step;
    logic apply;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
  } ctl_sts_t;

  // Places the pins of the first LEVEL_W axes into a level field.
  function automatic logic [LEVEL_W-1:0] pack_levels(input logic [AXES-1:0] v);
    logic [AXES+LEVEL_W-1:0] w;
    w = {{LEVEL_W{1'b0}}, v};
    return w[LEVEL_W-1:0];
  endfunction

endpackage

>>> sv/msspg_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command words and the result words.
// Depends on msspg_pkg for the field widths.
interface msspg_in_if;
  logic                              valid;
  logic                              ready;
  logic [msspg_pkg::OP_W-1:0]        operation;
  logic [msspg_pkg::AXIS_W-1:0]      axis;
  logic [msspg_pkg::VAL_W-1:0]       value;

  modport source (output valid, output operation, output axis, output value,
                  input ready);
  modport sink   (input valid, input operation, input axis, input value,
                  output ready);
endinterface

interface msspg_out_if;
  logic                               valid;
  logic                               ready;
  logic [msspg_pkg::LEVEL_W-1:0]      step_levels;
  logic [msspg_pkg::LEVEL_W-1:0]      direction_levels;
  logic [msspg_pkg::LEVEL_W-1:0]      enable_n_levels;
  logic [msspg_pkg::LEVEL_W-1:0]      stepped;
  logic signed [msspg_pkg::POS_W-1:0] position;

  modport source (output valid, output step_levels, output direction_levels,
                  output enable_n_levels, output stepped, output position,
                  input ready);
  modport sink   (input valid, input step_levels, input direction_levels,
                  input enable_n_levels, input stepped, input position,
                  output ready);
endinterface

>>> sv/msspg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the step pulse generator: per-axis state, the serial divider
// for speed commands and the result register. Depends on msspg_pkg.
module msspg_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msspg_pkg::ctl_cmd_t                 cmd,
  output msspg_pkg::ctl_sts_t                 sts,
  input  logic                                cfg_wr_en,
  input  logic [msspg_pkg::NUM_AXES_W-1:0]    cfg_wr_data,
  input  logic [msspg_pkg::OP_W-1:0]          in_operation,
  input  logic [msspg_pkg::AXIS_W-1:0]        in_axis,
  input  logic [msspg_pkg::VAL_W-1:0]         in_value,
  output logic [msspg_pkg::LEVEL_W-1:0]       out_step_levels,
  output logic [msspg_pkg::LEVEL_W-1:0]       out_direction_levels,
  output logic [msspg_pkg::LEVEL_W-1:0]       out_enable_n_levels,
  output logic [msspg_pkg::LEVEL_W-1:0]       out_stepped,
  output logic signed [msspg_pkg::POS_W-1:0]  out_position
);
  import msspg_pkg::*;

  logic [NUM_AXES_W-1:0] num_axes_r;

  logic [OP_W-1:0]   op_r;
  logic [AXIS_W-1:0] ax_r;
  logic [VAL_W-1:0]  val_r;

  logic [VAL_W-1:0]  quot_r, quot_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W:0]    rem_shift;

  logic [VAL_W-1:0]  countdown_r [AXES];
  logic [VAL_W-1:0]  countdown_nxt [AXES];
  logic [VAL_W-1:0]  reload_r [AXES];
  logic [VAL_W-1:0]  reload_nxt [AXES];
  logic [SIGN_W-1:0] sign_r [AXES];
  logic [SIGN_W-1:0] sign_nxt [AXES];
  logic [POS_W-1:0]  pos_r [AXES];
  logic [POS_W-1:0]  pos_nxt [AXES];
  logic [AXES-1:0]   phase_r, phase_nxt;
  logic [AXES-1:0]   step_r, step_nxt;
  logic [AXES-1:0]   dir_r, dir_nxt;
  logic [AXES-1:0]   en_n_r, en_n_nxt;
  logic [AXES-1:0]   stepped_v;
  logic [AXES-1:0]   lane_on;
  logic [AXES-1:0]   hit;
  logic [POS_W-1:0]  pos_sel;

  assign sts.need_div = (op_t'(in_operation) == OP_SET_SPEED) && (in_value != '0);

  // One restoring step with a dividend of all ones: shift in a one bit.
  always_comb begin
    rem_shift = {rem_r, 1'b1};
    if (rem_shift >= {1'b0, val_r}) begin
      rem_nxt  = VAL_W'(rem_shift - {1'b0, val_r});
      quot_nxt = {quot_r[VAL_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_shift[VAL_W-1:0];
      quot_nxt = {quot_r[VAL_W-2:0], 1'b0};
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      lane_on[i] = AXIS_W'(i) < num_axes_r;
      hit[i]     = lane_on[i] && (ax_r == AXIS_W'(i));
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    en_n_nxt  = en_n_r;
    stepped_v = '0;
    for (int i = 0; i < AXES; i++) begin
      countdown_nxt[i] = countdown_r[i];
      reload_nxt[i]    = reload_r[i];
      sign_nxt[i]      = sign_r[i];
      pos_nxt[i]       = pos_r[i];
      unique case (op_t'(op_r))
        OP_TICK: begin
          if (lane_on[i]) begin
            if (countdown_r[i] != '0) begin
              countdown_nxt[i] = countdown_r[i] - 1'b1;
            end else begin
              if (reload_r[i] != '0) begin
                step_nxt[i]  = phase_r[i];
                phase_nxt[i] = ~phase_r[i];
                pos_nxt[i]   = pos_r[i] + {{(POS_W-SIGN_W){sign_r[i][SIGN_W-1]}}, sign_r[i]};
                stepped_v[i] = 1'b1;
              end
              countdown_nxt[i] = reload_r[i];
            end
          end
        end
        OP_SET_DELAY: begin
          if (hit[i]) reload_nxt[i] = val_r;
        end
        OP_SET_SPEED: begin
          if (hit[i]) reload_nxt[i] = (val_r != '0) ? quot_r : '0;
        end
        OP_SET_DIR: begin
          if (hit[i]) begin
            dir_nxt[i]  = (val_r != '0);
            sign_nxt[i] = (val_r == VAL_W'(1)) ? SIGN_FWD : SIGN_REV;
          end
        end
        OP_ENABLE: begin
          if (hit[i]) en_n_nxt[i] = 1'b0;
        end
        OP_DISABLE: begin
          if (hit[i]) en_n_nxt[i] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // An axis number at or beyond AXES matches no lane and reports zero.
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < AXES; i++) begin
      if ({1'b0, ax_r} == (AXIS_W + 1)'(i)) pos_sel = pos_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_axes_r <= '0;
    end else if (cfg_wr_en) begin
      num_axes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_operation;
      ax_r   <= in_axis;
      val_r  <= in_value;
      quot_r <= '0;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      dir_r   <= '0;
      en_n_r  <= '0;
      for (int i = 0; i < AXES; i++) begin
        countdown_r[i] <= '0;
        reload_r[i]    <= '0;
        sign_r[i]      <= '0;
        pos_r[i]       <= '0;
      end
    end else if (cmd.apply) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
      en_n_r  <= en_n_nxt;
      for (int i = 0; i < AXES; i++) begin
        countdown_r[i] <= countdown_nxt[i];
        reload_r[i]    <= reload_nxt[i];
        sign_r[i]      <= sign_nxt[i];
        pos_r[i]       <= pos_nxt[i];
      end
    end
  end

  // Result register, loaded with the state as it stands after the word.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_step_levels      <= pack_levels(step_nxt);
      out_direction_levels <= pack_levels(dir_nxt);
      out_enable_n_levels  <= pack_levels(en_n_nxt);
      out_stepped          <= pack_levels(stepped_v);
      out_position         <= signed'(pos_sel);
    end
  end

endmodule

>>> sv/msspg_ctrl.sv
`timescale 1ns / 1ps
// Controller of the step pulse generator: sequences load, division and
// update, and owns both handshakes. Depends on msspg_pkg.
module msspg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  msspg_pkg::ctl_sts_t  sts,
  output msspg_pkg::ctl_cmd_t  cmd
);
  import msspg_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = sts.need_div ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (!out_valid_r || out_ready) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result register is never overwritten while a word still waits.
  a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || out_ready))
    else $error("update while result register is occupied");

  a_apply_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid_r)
    else $error("result not presented after update");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (cnt_r == '0))
    else $error("division counter not at zero outside division");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == DIV_LAST) |=> (state_r == ST_APPLY))
    else $error("division did not end after its last step");

endmodule

>>> sv/multi_axis_step_pulse_generator.sv
`timescale 1ns / 1ps
// Top level of the multi-axis step pulse generator. Depends on msspg_pkg,
// the channel interfaces, msspg_ctrl and msspg_datapath.
//
// Usage: each word on in_ch is a command (operation, axis, value). A tick
// word advances every axis below num_axes; the other operations set the
// reload delay, the speed (stored as 65535 / speed), the direction or the
// active-low enable of one axis. Every word returns exactly one result word
// on out_ch with the pin levels, the axes that stepped on this tick and the
// position of the addressed axis after the word.
// num_axes is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block idles; the block itself does not enforce this.
// A word is accepted only in the idle state, so no new word is taken until
// the update for the last one is done. A set-speed word with a nonzero
// speed first goes through a restoring divider that makes one quotient bit
// per cycle. The update then loads the result register and sets its valid.
// Reset clears all axis state and num_axes, so no axis is in use.
// When the receiver stalls, the finished result waits in the output
// register while the next word is still accepted and worked on; its update
// then waits until the earlier result is taken.
module multi_axis_step_pulse_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [msspg_pkg::NUM_AXES_W-1:0]    cfg_wr_data,
  msspg_in_if.sink                            in_ch,
  msspg_out_if.source                         out_ch
);
  import msspg_pkg::*;

  // Command and status between the sequencer and the datapath.
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // The controller owns the handshakes; the datapath holds every axis and
  // the result register.
  msspg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msspg_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_operation         (in_ch.operation),
    .in_axis              (in_ch.axis),
    .in_value             (in_ch.value),
    .out_step_levels      (out_ch.step_levels),
    .out_direction_levels (out_ch.direction_levels),
    .out_enable_n_levels  (out_ch.enable_n_levels),
    .out_stepped          (out_ch.stepped),
    .out_position         (out_ch.position)
  );

endmodule
